FILE: sv/ebs_pkg.sv
// Shared constants, command codes and control structs for the embedding bag sum block.
package ebs_pkg;

	localparam int ROWS = 1024;
	localparam int DIM  = 16;

	localparam int CMD_W    = 2;
	localparam int ROW_W    = 10;
	localparam int ELEM_W   = 6;
	localparam int WEIGHT_W = 16;
	localparam int SUM_W    = 32;

	localparam int DEPTH  = ROWS * DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd2;

	typedef struct packed {
		logic             wr_en;
		logic             load_row;
		logic             rd_en;
		logic             emit_en;
		logic [IDX_W-1:0] idx;
	} ebs_cmd_t;

	typedef struct packed {
		logic out_free;
	} ebs_sts_t;

	function automatic logic row_ok(input logic [ROW_W-1:0] row);
		return 32'(row) < 32'(ROWS);
	endfunction

	function automatic logic elem_ok(input logic [ELEM_W-1:0] elem);
		return 32'(elem) < 32'(DIM);
	endfunction

endpackage

FILE: sv/ebs_intf.sv
// Valid/ready channel interfaces for command beats and result beats.
interface ebs_in_if import ebs_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           cmd;
	logic [ROW_W-1:0]           row_index;
	logic [ELEM_W-1:0]          element_index;
	logic signed [WEIGHT_W-1:0] weight_value;
	logic                       bag_end;

	modport source(output valid, cmd, row_index, element_index, weight_value, bag_end,
		input ready);
	modport sink(input valid, cmd, row_index, element_index, weight_value, bag_end,
		output ready);
endinterface

interface ebs_out_if import ebs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum_value;
	logic [ELEM_W-1:0]       out_element;
	logic                    last_element;

	modport source(output valid, sum_value, out_element, last_element, input ready);
	modport sink(input valid, sum_value, out_element, last_element, output ready);
endinterface

FILE: sv/embedding_bag_sum_top.sv
// Embedding bag sum pooling block: top level joining controller and datapath.
//
// The block keeps a table of ROWS x DIM signed Q8.8 weights in a single-port
// style memory and pools rows into a DIM-wide saturating 32-bit accumulator.
// A write beat (cmd 0) stores one element; writes outside the table are
// dropped. A lookup beat (cmd 1) reads the named row one element per cycle
// from the table memory: the beat is taken and the row latched, the DIM
// elements are read, and the last registered read is then added; the single
// table read port sets that pace. A lookup flagged bag_end, or a close beat
// (cmd 2), then streams the DIM sums out one beat per cycle while the sink
// keeps ready high, element 0 first, last_element set on element DIM-1,
// clearing each accumulator entry as it goes; emission stalls beat by beat
// when the sink holds ready low. The input is taken only while the
// controller is idle; the last result beat may still wait in the output
// register while the next input beat is accepted. Table contents are
// undefined until written; the accumulator resets to zero.
module embedding_bag_sum_top import ebs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ebs_in_if.sink    in_ch,
	ebs_out_if.source out_ch
);

	ebs_cmd_t cmd;
	ebs_sts_t sts;

	// sequence the beats
	ebs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_cmd     (in_ch.cmd),
		.in_row     (in_ch.row_index),
		.in_bag_end (in_ch.bag_end),
		.in_ready   (in_ch.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// hold table, sums and the result beat
	ebs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_row    (in_ch.row_index),
		.in_elem   (in_ch.element_index),
		.in_weight (in_ch.weight_value),
		.cmd       (cmd),
		.sts       (sts),
		.out_ch    (out_ch)
	);

	// emission only into a free output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_en |-> (!out_ch.valid || out_ch.ready))
		else $error("result beat overwritten before it was taken");

	// an emitted beat shows up next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_en |=> out_ch.valid)
		else $error("emitted beat missing on output");

	// last flag follows the final element index
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_en && (cmd.idx == IDX_LAST) |=> out_ch.last_element)
		else $error("last_element not set on final beat");

	// no input taken while a row is being read
	a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ch.ready)
		else $error("input accepted during lookup");

endmodule

FILE: sv/ebs_ctrl.sv
// Controller state machine: sequences table writes, row lookups and bag emission.
module ebs_ctrl import ebs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	input  logic [ROW_W-1:0] in_row,
	input  logic             in_bag_end,
	output logic             in_ready,
	input  ebs_sts_t         sts,
	output ebs_cmd_t         cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOKUP = 2'd1;
	localparam logic [1:0] S_WAIT   = 2'd2;
	localparam logic [1:0] S_EMIT   = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             bag_q, bag_d;
	logic             accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		bag_d       = bag_q;
		cmd.wr_en    = 1'b0;
		cmd.load_row = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.emit_en  = 1'b0;
		cmd.idx      = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cnt_d = '0;
					unique case (in_cmd)
						CMD_WRITE: begin
							cmd.wr_en = 1'b1;
						end
						CMD_LOOKUP: begin
							bag_d = in_bag_end;
							if (row_ok(in_row)) begin
								cmd.load_row = 1'b1;
								state_d      = S_LOOKUP;
							end else if (in_bag_end) begin
								state_d = S_EMIT;
							end
						end
						CMD_CLOSE: begin
							state_d = S_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			S_LOOKUP: begin
				// one table read per cycle; the add lands in the following cycle
				cmd.rd_en = 1'b1;
				if (cnt_q == IDX_LAST) begin
					cnt_d   = '0;
					state_d = S_WAIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_WAIT: begin
				// let the final element add settle before any read-out
				cnt_d   = '0;
				state_d = bag_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_en = 1'b1;
					if (cnt_q == IDX_LAST) begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			bag_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bag_q   <= bag_d;
		end
	end

endmodule

FILE: sv/ebs_dp.sv
// Datapath: table memory, per-element saturating accumulator and result register.
module ebs_dp import ebs_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ROW_W-1:0]           in_row,
	input  logic [ELEM_W-1:0]          in_elem,
	input  logic signed [WEIGHT_W-1:0] in_weight,
	input  ebs_cmd_t                   cmd,
	output ebs_sts_t                   sts,
	ebs_out_if.source                  out_ch
);

	logic signed [WEIGHT_W-1:0] mem [DEPTH];
	logic signed [SUM_W-1:0]    acc_q [DIM];

	logic [ROW_W-1:0]           row_q;
	logic [ADDR_W-1:0]          wr_addr, rd_addr;
	logic signed [WEIGHT_W-1:0] rdata_s1;
	logic                       acc_en_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic signed [SUM_W:0]      sum_wide;
	logic signed [SUM_W-1:0]    sum_sat;
	logic                       out_valid_q;
	logic signed [SUM_W-1:0]    out_sum_q;
	logic [ELEM_W-1:0]          out_elem_q;
	logic                       out_last_q;

	assign wr_addr = ADDR_W'(32'(in_row) * 32'(DIM) + 32'(in_elem));
	assign rd_addr = ADDR_W'(32'(row_q) * 32'(DIM) + 32'(cmd.idx));

	always_ff @(posedge clk) begin
		if (cmd.wr_en && row_ok(in_row) && elem_ok(in_elem)) begin
			mem[wr_addr] <= in_weight;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (cmd.load_row) begin
			row_q <= in_row;
		end
		idx_s1 <= cmd.idx;
	end

	// saturate to the signed 32-bit range
	assign sum_wide = {acc_q[idx_s1][SUM_W-1], acc_q[idx_s1]} + (SUM_W+1)'(rdata_s1);
	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
			for (int i = 0; i < DIM; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			acc_en_s1 <= cmd.rd_en;
			if (acc_en_s1) begin
				acc_q[idx_s1] <= sum_sat;
			end else if (cmd.emit_en) begin
				acc_q[cmd.idx] <= '0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_en) begin
			out_sum_q  <= acc_q[cmd.idx];
			out_elem_q <= ELEM_W'(cmd.idx);
			out_last_q <= (cmd.idx == IDX_LAST);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sum_value    = out_sum_q;
	assign out_ch.out_element  = out_elem_q;
	assign out_ch.last_element = out_last_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the embedding bag sum pooling block.
module tb_top;
	import ebs_pkg::*;

	// Command 3 has no meaning; the block must drop it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Counted beats of random traffic; with the directed and long-bag tests
	// the run sends about 320 beats. Dropped beats do not count.
	localparam int RAND_BEATS   = 260;
	// Lookups in the long bag of extreme weights.
	localparam int LONG_LOOKUPS = 16;
	// The random part adds sender gaps and random stalls on the result
	// beats. Allow several times the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic [ELEM_W-1:0]       elem;
		logic                    last;
	} pooled_sum_t;

	logic clk = 1'b0;
	logic arst_n;

	ebs_in_if  in_ch();
	ebs_out_if out_ch();

	embedding_bag_sum_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: a copy of the table, a flag for each table entry that
	// has been written, and the running sums of the open bag.
	logic signed [WEIGHT_W-1:0] weight_shadow [DEPTH];
	bit                         entry_written [DEPTH];
	int                         row_fill      [ROWS];
	int                         lookup_rows   [$];   // rows written in full
	logic signed [SUM_W-1:0]    pool_sums     [DIM];
	pooled_sum_t                pending_sums  [$];

	int          err_count  = 0;
	int          live_beats = 0;   // accepted beats that the block acts on
	bit          idle_on    = 1'b0;
	int          stall_left = 0;
	int unsigned cycle_count = 0;

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Queue the open bag's sums in element order, then clear them.
	function automatic void emit_pooled();
		pooled_sum_t beat;
		for (int e = 0; e < DIM; e++) begin
			beat.sum  = pool_sums[e];
			beat.elem = ELEM_W'(e);
			beat.last = (e == DIM - 1);
			pending_sums.push_back(beat);
			pool_sums[e] = '0;
		end
	endfunction

	// Apply one accepted command beat to the predictor state.
	function automatic void predict_pooling(
		input logic [CMD_W-1:0]           cmd,
		input logic [ROW_W-1:0]           row,
		input logic [ELEM_W-1:0]          elem,
		input logic signed [WEIGHT_W-1:0] wt,
		input logic                       bag_end
	);
		int                    base;
		logic signed [SUM_W:0] w_ext;
		logic signed [SUM_W:0] wide;
		base = int'(row) * DIM;
		case (cmd)
			CMD_WRITE: begin
				// Drop writes outside the table.
				if (int'(row) < ROWS && int'(elem) < DIM) begin
					live_beats++;
					weight_shadow[base + int'(elem)] = wt;
					if (!entry_written[base + int'(elem)]) begin
						entry_written[base + int'(elem)] = 1'b1;
						row_fill[row]++;
						if (row_fill[row] == DIM)
							lookup_rows.push_back(int'(row));
					end
				end
			end
			CMD_LOOKUP: begin
				live_beats++;
				if (int'(row) < ROWS) begin
					for (int e = 0; e < DIM; e++) begin
						w_ext = weight_shadow[base + e];
						wide  = pool_sums[e] + w_ext;
						// Clip when the carry into the sign bit disagrees with it.
						if (wide[SUM_W] != wide[SUM_W-1])
							pool_sums[e] = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
								: {1'b0, {(SUM_W-1){1'b1}}};
						else
							pool_sums[e] = wide[SUM_W-1:0];
					end
				end
				if (bag_end)
					emit_pooled();
			end
			CMD_CLOSE: begin
				// Ignore bag_end here; a close always flushes the bag.
				live_beats++;
				emit_pooled();
			end
			default: ;
		endcase
	endfunction

	// Send one command beat. Sometimes lower valid for a random gap first if
	// idling is on. Hold valid and the payload until ready, then predict the beat.
	// Leave valid high after the beat: the next call either replaces the
	// payload at the following falling edge or drops valid.
	task automatic send_beat(
		input logic [CMD_W-1:0]           cmd,
		input logic [ROW_W-1:0]           row,
		input logic [ELEM_W-1:0]          elem,
		input logic signed [WEIGHT_W-1:0] wt,
		input logic                       bag_end
	);
		int gap;
		gap = 0;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.cmd           <= cmd;
		in_ch.row_index     <= row;
		in_ch.element_index <= elem;
		in_ch.weight_value  <= wt;
		in_ch.bag_end       <= bag_end;
		do @(posedge clk); while (!in_ch.ready);
		predict_pooling(cmd, row, elem, wt, bag_end);
	endtask

	// Drop valid once the test stops sending.
	task automatic release_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Prefer the extremes, since they drive the sums hardest.
	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0:       return {1'b0, {(WEIGHT_W-1){1'b1}}};
			1:       return {1'b1, {(WEIGHT_W-1){1'b0}}};
			2:       return '0;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// Write every element of a row, starting at a random element and
	// wrapping around. Set bag_end at random; the block must ignore it.
	task automatic fill_row(input int row);
		int start;
		start = $urandom_range(0, DIM - 1);
		for (int k = 0; k < DIM; k++)
			send_beat(CMD_WRITE, ROW_W'(row), ELEM_W'((start + k) % DIM),
				pick_weight(), 1'($urandom));
	endtask

	// Pool a bag over rows that are written in full. Sometimes rewrite an
	// element before a lookup. Close the bag either with bag_end on the
	// last lookup or with a close command.
	task automatic pool_bag(input int lookups);
		bit by_close;
		int row;
		by_close = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < lookups; n++) begin
			row = lookup_rows[$urandom_range(0, lookup_rows.size() - 1)];
			if ($urandom_range(0, 4) == 0)
				send_beat(CMD_WRITE, ROW_W'(row), ELEM_W'($urandom_range(0, DIM - 1)),
					pick_weight(), 1'($urandom));
			send_beat(CMD_LOOKUP, ROW_W'(row), ELEM_W'($urandom),
				WEIGHT_W'($urandom), !by_close && (n == lookups - 1));
		end
		if (by_close)
			send_beat(CMD_CLOSE, ROW_W'($urandom), ELEM_W'($urandom),
				WEIGHT_W'($urandom), 1'($urandom));
	endtask

	// Directed beats: extreme weights, every command, stray bag_end, writes
	// past the row end, the unused command, an empty close, and a bag closed
	// by a close command after a lookup.
	task automatic test_directed();
		logic signed [WEIGHT_W-1:0] corner [8];
		corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
			16'shFFFF, 16'sh0100, 16'shFF00, 16'sh5A5A};
		for (int e = 0; e < DIM; e++)
			send_beat(CMD_WRITE, '0, ELEM_W'(e), corner[e % 8], 1'(e % 2));
		// Writes past the row end; they must not alias onto the row.
		send_beat(CMD_WRITE, '0, ELEM_W'(DIM), 16'sh1234, 1'b0);
		send_beat(CMD_WRITE, '0, {ELEM_W{1'b1}}, 16'shA5A5, 1'b1);
		send_beat(CMD_UNUSED, {ROW_W{1'b1}}, {ELEM_W{1'b1}}, 16'shFFFF, 1'b1);
		send_beat(CMD_CLOSE, {ROW_W{1'b1}}, {ELEM_W{1'b1}}, 16'sh7FFF, 1'b1);
		send_beat(CMD_LOOKUP, '0, '0, '0, 1'b0);
		send_beat(CMD_LOOKUP, '0, '0, '0, 1'b1);
		send_beat(CMD_LOOKUP, '0, {ELEM_W{1'b1}}, 16'sh8000, 1'b0);
		send_beat(CMD_CLOSE, '0, '0, '0, 1'b0);
	endtask

	// Random traffic. Most of it is well-formed: rows written in full and
	// bags pooled over them. The rest is empty closes, partial writes and
	// noise.
	task automatic test_random_bags();
		int start;
		int pick;
		idle_on = 1'b1;
		start   = live_beats;
		while (live_beats - start < RAND_BEATS) begin
			pick = $urandom_range(0, 99);
			if (lookup_rows.size() < 3 || pick < 12)
				fill_row($urandom_range(0, ROWS - 1));
			else if (pick < 72)
				pool_bag($urandom_range(1, 4));
			else if (pick < 80)
				send_beat(CMD_CLOSE, ROW_W'($urandom), ELEM_W'($urandom),
					WEIGHT_W'($urandom), 1'($urandom));
			else if (pick < 92)
				// Partial or out-of-range writes; only rows written in full
				// are ever looked up.
				send_beat(CMD_WRITE, ROW_W'($urandom), ELEM_W'($urandom),
					pick_weight(), 1'($urandom));
			else
				send_beat(CMD_UNUSED, ROW_W'($urandom), ELEM_W'($urandom),
					WEIGHT_W'($urandom), 1'($urandom));
		end
	endtask

	// Pool one long bag back to back: the low half of the last row holds the
	// largest weight and the high half the smallest. Run with no idling.
	task automatic test_long_bag();
		idle_on = 1'b0;
		for (int e = 0; e < DIM; e++)
			send_beat(CMD_WRITE, ROW_W'(ROWS - 1), ELEM_W'(e),
				(e < DIM / 2) ? 16'sh7FFF : 16'sh8000, 1'b0);
		for (int n = 0; n < LONG_LOOKUPS; n++)
			send_beat(CMD_LOOKUP, ROW_W'(ROWS - 1), '0, '0, n == LONG_LOOKUPS - 1);
	endtask

	// Wait until every expected sum has arrived, then let the block settle.
	task automatic wait_drained();
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (4 * DIM) @(posedge clk);
	endtask

	// Result sink: hold ready low in random bursts while idling is on.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Check each result beat against the oldest expected sum.
	always @(posedge clk) begin
		pooled_sum_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat, element %0d sum %0d",
					out_ch.out_element, out_ch.sum_value));
			end else begin
				want = pending_sums.pop_front();
				if (out_ch.sum_value !== want.sum)
					report_mismatch($sformatf("element %0d: sum %0d, want %0d",
						want.elem, out_ch.sum_value, want.sum));
				if (out_ch.out_element !== want.elem)
					report_mismatch($sformatf("out_element %0d, want %0d",
						out_ch.out_element, want.elem));
				if (out_ch.last_element !== want.last)
					report_mismatch($sformatf("element %0d: last_element %0b, want %0b",
						want.elem, out_ch.last_element, want.last));
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.cmd           = CMD_WRITE;
		in_ch.row_index     = '0;
		in_ch.element_index = '0;
		in_ch.weight_value  = '0;
		in_ch.bag_end       = 1'b0;
		out_ch.ready        = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			weight_shadow[i] = '0;
			entry_written[i] = 1'b0;
		end
		for (int r = 0; r < ROWS; r++)
			row_fill[r] = 0;
		for (int e = 0; e < DIM; e++)
			pool_sums[e] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_bags();
		test_long_bag();
		release_input();
		wait_drained();

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ebs_pkg.sv
sv/ebs_intf.sv
sv/ebs_ctrl.sv
sv/ebs_dp.sv
sv/embedding_bag_sum_top.sv
test/tb_top.sv
